// ===== src/multitap_key_to_char_core_macros.svh =====
// Assertion macros shared by the multi-tap text entry RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef MULTITAP_KEY_TO_CHAR_CORE_MACROS_SVH
`define MULTITAP_KEY_TO_CHAR_CORE_MACROS_SVH
`ifndef SYNTH
`define MTK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MTK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTK_ASSERT(label, clk, rst, prop, msg)
`define MTK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/mtk_pkg.sv =====
// Package for the multi-tap text entry block: constants, character table and types.
// No dependencies.
`default_nettype none
package mtk_pkg;
   localparam int unsigned TAPS_PER_KEY = 10;
   localparam int unsigned TAP_W = 4;
   localparam int unsigned TABLE_COLS = 10;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_KEY = 1'b1;

   localparam logic [7:0] KEY_BASE = 8'd48;
   localparam logic [7:0] BACKSPACE = 8'd8;
   localparam logic [7:0] FALLBACK_CHAR = 8'h30;
   localparam logic [7:0] DIGIT_LO = 8'h30;
   localparam logic [7:0] DIGIT_HI = 8'h39;
   localparam logic [7:0] TIMEOUT_RESET = 8'd3;
   localparam logic [7:0] TICKS_MAX = 8'd255;

   localparam logic [7:0] CHAR_TABLE [TABLE_COLS][TABLE_COLS] = '{
      '{8'd48, 8'd61, 8'd123, 8'd124, 8'd125, 8'd126, 8'd252, 8'd253, 8'd254, 8'd255},
      '{8'd97, 8'd98, 8'd99, 8'd49, 8'd65, 8'd66, 8'd67, 8'd33, 8'd34, 8'd62},
      '{8'd100, 8'd101, 8'd102, 8'd50, 8'd68, 8'd69, 8'd70, 8'd35, 8'd36, 8'd63},
      '{8'd103, 8'd104, 8'd105, 8'd51, 8'd71, 8'd72, 8'd73, 8'd37, 8'd38, 8'd64},
      '{8'd106, 8'd107, 8'd108, 8'd52, 8'd74, 8'd75, 8'd76, 8'd39, 8'd40, 8'd91},
      '{8'd109, 8'd110, 8'd111, 8'd53, 8'd77, 8'd78, 8'd79, 8'd41, 8'd42, 8'd92},
      '{8'd112, 8'd113, 8'd114, 8'd54, 8'd80, 8'd81, 8'd82, 8'd43, 8'd44, 8'd93},
      '{8'd115, 8'd116, 8'd117, 8'd55, 8'd83, 8'd84, 8'd85, 8'd45, 8'd46, 8'd94},
      '{8'd118, 8'd119, 8'd120, 8'd56, 8'd86, 8'd87, 8'd88, 8'd47, 8'd58, 8'd95},
      '{8'd121, 8'd122, 8'd169, 8'd57, 8'd89, 8'd90, 8'd229, 8'd59, 8'd60, 8'd96}
   };

   typedef struct packed {
      logic has_bs;
      logic [7:0] ch;
   } mtk_result_type;

   function automatic logic [7:0] lookup_char(input logic [7:0] key_char,
                                              input logic [TAP_W-1:0] tap);
      logic [7:0] offset;
      offset = key_char - DIGIT_LO;
      if (key_char < DIGIT_LO || key_char > DIGIT_HI) begin
         return FALLBACK_CHAR;
      end
      if (32'(tap) >= TABLE_COLS) begin
         return FALLBACK_CHAR;
      end
      return CHAR_TABLE[offset[3:0]][tap];
   endfunction
endpackage
`default_nettype wire

// ===== src/mtk_if.sv =====
// Valid/ready channel interfaces for the multi-tap text entry block.
// Depends on nothing; the top level uses all three.
`default_nettype none
interface mtk_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [7:0] key_code;
   modport source (output valid, output mode, output key_code, input ready);
   modport sink (input valid, input mode, input key_code, output ready);
endinterface

interface mtk_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_char;
   logic last;
   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

interface mtk_csr_if;
   logic valid;
   logic ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mtk_tap_ctrl.sv =====
// Tap state tracker: elapsed tick counter, previous key and tap index.
// Depends on mtk_pkg for constants, the character table and the result type.
`default_nettype none
module mtk_tap_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire logic                   mode,
   input  wire logic [7:0]             key_code,
   input  wire logic [7:0]             repeat_timeout,
   output mtk_pkg::mtk_result_type     result
);
   logic [7:0] elapsed_ff, elapsed_in;
   logic [7:0] prev_key_ff, prev_key_in;
   logic [mtk_pkg::TAP_W-1:0] tap_ff, tap_in;
   logic [7:0] key_char;
   logic is_repeat;
   logic [mtk_pkg::TAP_W:0] tap_inc;
   logic [mtk_pkg::TAP_W-1:0] tap_next;

   assign key_char = key_code + mtk_pkg::KEY_BASE;
   assign is_repeat = (elapsed_ff <= repeat_timeout) && (key_char == prev_key_ff);
   assign tap_inc = {1'b0, tap_ff} + {{mtk_pkg::TAP_W{1'b0}}, 1'b1};

   always_comb begin
      if (!is_repeat) begin
         tap_next = '0;
      end else if (tap_inc >= (mtk_pkg::TAP_W + 1)'(mtk_pkg::TAPS_PER_KEY)) begin
         tap_next = '0;
      end else begin
         tap_next = tap_inc[mtk_pkg::TAP_W-1:0];
      end
   end

   assign result.has_bs = is_repeat;
   assign result.ch = mtk_pkg::lookup_char(key_char, tap_next);

   always_comb begin
      elapsed_in = elapsed_ff;
      prev_key_in = prev_key_ff;
      tap_in = tap_ff;
      if (load) begin
         if (mode == mtk_pkg::MODE_TICK) begin
            if (elapsed_ff != mtk_pkg::TICKS_MAX) begin
               elapsed_in = elapsed_ff + 8'd1;
            end
         end else begin
            elapsed_in = '0;
            prev_key_in = key_char;
            tap_in = tap_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         prev_key_ff <= '0;
         tap_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         prev_key_ff <= prev_key_in;
         tap_ff <= tap_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/multitap_key_to_char_core.sv =====
// Multi-tap keypad to character converter, top level.
// A key item waits in the pending register; its results then go to the response register.
// Throughput: ticks and one-result keys go one per cycle while the output is not stalled;
// a repeat tap's backspace and character leave one per cycle; new items wait for the backspace.
// Reset (synchronous, active high) clears all tap state and sets the timeout to 3.
// Depends on mtk_pkg, the channel interfaces, mtk_tap_ctrl and the assertion macros.
`default_nettype none
`include "multitap_key_to_char_core_macros.svh"
module multitap_key_to_char_core (
   input  wire logic    clock,
   input  wire logic    reset,
   mtk_req_if.sink      req_chan,
   mtk_rsp_if.source    rsp_chan,
   mtk_csr_if.sink      csr_chan
);
   logic [7:0] timeout_ff, timeout_in;
   logic pend_valid_ff, pend_valid_in;
   logic pend_bs_ff, pend_bs_in;
   logic [7:0] pend_char_ff, pend_char_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic rsp_last_ff, rsp_last_in;
   logic accept;
   logic key_accept;
   logic out_free;
   mtk_pkg::mtk_result_type result;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !pend_valid_ff || (out_free && !pend_bs_ff);
   assign accept = req_chan.valid && req_chan.ready;
   assign key_accept = accept && (req_chan.mode == mtk_pkg::MODE_KEY);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_char = rsp_char_ff;
   assign rsp_chan.last = rsp_last_ff;

   mtk_tap_ctrl u_tap_ctrl (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .mode           (req_chan.mode),
      .key_code       (req_chan.key_code),
      .repeat_timeout (timeout_ff),
      .result         (result)
   );

   assign timeout_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : timeout_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_bs_in = pend_bs_ff;
      pend_char_in = pend_char_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            if (pend_bs_ff) begin
               rsp_char_in = mtk_pkg::BACKSPACE;
               rsp_last_in = 1'b0;
               pend_bs_in = 1'b0;
            end else begin
               rsp_char_in = pend_char_ff;
               rsp_last_in = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
      end
      if (key_accept) begin
         pend_valid_in = 1'b1;
         pend_bs_in = result.has_bs;
         pend_char_in = result.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= mtk_pkg::TIMEOUT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff <= timeout_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_bs_ff <= pend_bs_in;
      pend_char_ff <= pend_char_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   `MTK_ASSERT(a_mid_is_backspace, clock, reset, (rsp_valid_ff && !rsp_last_ff) |-> (rsp_char_ff == mtk_pkg::BACKSPACE), "Non-final result is not a backspace.")
   `MTK_ASSERT(a_char_follows_bs, clock, reset, (rsp_valid_ff && !rsp_last_ff && rsp_chan.ready) |=> (rsp_valid_ff && rsp_last_ff), "Character did not follow its backspace.")
   `MTK_ASSERT(a_key_goes_pending, clock, reset, key_accept |=> pend_valid_ff, "Accepted key item was not captured.")
   `MTK_ASSERT(a_tick_no_result, clock, reset, (accept && !key_accept) |=> (pend_valid_ff == 1'b0), "Tick item produced a result.")
endmodule
`default_nettype wire
